// ===== sv/length_prefixed_frame_deframer_defines.svh =====
// Assertion macros used by the checker file lpfd_checker.sv.
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_DEFINES_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_DEFINES_SVH

// Checked on every rising edge of clock outside reset.
`define LPFD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked on every rising edge of clock, reset included.
`define LPFD_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ===== sv/lpfd_pkg.sv =====
`default_nettype none
package lpfd_pkg;

   typedef enum logic [2:0] {
      PH_CONN_HI = 3'd0,
      PH_CONN_LO = 3'd1,
      PH_CTRL_HI = 3'd2,
      PH_CTRL_LO = 3'd3,
      PH_LEN_HI  = 3'd4,
      PH_LEN_LO  = 3'd5,
      PH_PAYLOAD = 3'd6
   } phase_type;

   typedef struct packed {
      logic [15:0] connection_id;
      logic [15:0] control_field;
      logic [15:0] payload_length;
      logic [7:0]  payload_byte;
      logic        has_data;
      logic        frame_end;
   } rsp_type;

endpackage
`default_nettype wire

// ===== sv/lpfd_in_stage.sv =====
`default_nettype none
module lpfd_in_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   input  logic       take,
   output logic       byte_valid,
   output logic [7:0] byte_data
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       load;

   assign req_stall  = valid_ff & ~take;
   assign load       = req_valid & ~req_stall;
   assign byte_valid = valid_ff;
   assign byte_data  = byte_ff;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= req_rx_byte;
      end
   end

endmodule
`default_nettype wire

// ===== sv/lpfd_parser.sv =====
`default_nettype none
module lpfd_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             byte_valid,
   input  logic [7:0]       byte_data,
   input  logic             out_ready,
   output logic             take,
   output logic             emit,
   output lpfd_pkg::rsp_type result
);

   lpfd_pkg::phase_type phase_ff;
   lpfd_pkg::phase_type phase_in;
   logic [15:0] conn_ff;
   logic [15:0] conn_in;
   logic [15:0] ctrl_ff;
   logic [15:0] ctrl_in;
   logic [15:0] len_ff;
   logic [15:0] len_in;
   logic [15:0] left_ff;
   logic [15:0] left_in;
   logic [15:0] len_full;
   logic        empty_frame;
   logic        last_byte;
   logic        needs_out;

   assign len_full    = {len_ff[15:8], byte_data};
   assign empty_frame = (phase_ff == lpfd_pkg::PH_LEN_LO) && (len_full == 16'd0);
   assign last_byte   = (left_ff == 16'd1);
   assign needs_out   = empty_frame || (phase_ff == lpfd_pkg::PH_PAYLOAD);
   assign take        = byte_valid & (~needs_out | out_ready);
   assign emit        = take & needs_out;

   // Next state and header registers.
   always_comb begin
      phase_in = phase_ff;
      conn_in  = conn_ff;
      ctrl_in  = ctrl_ff;
      len_in   = len_ff;
      left_in  = left_ff;
      if (take) begin
         unique case (phase_ff)
            lpfd_pkg::PH_CONN_LO: begin
               conn_in  = {conn_ff[15:8], byte_data};
               phase_in = lpfd_pkg::PH_CTRL_HI;
            end
            lpfd_pkg::PH_CTRL_HI: begin
               ctrl_in  = {byte_data, 8'd0};
               phase_in = lpfd_pkg::PH_CTRL_LO;
            end
            lpfd_pkg::PH_CTRL_LO: begin
               ctrl_in  = {ctrl_ff[15:8], byte_data};
               phase_in = lpfd_pkg::PH_LEN_HI;
            end
            lpfd_pkg::PH_LEN_HI: begin
               len_in   = {byte_data, 8'd0};
               phase_in = lpfd_pkg::PH_LEN_LO;
            end
            lpfd_pkg::PH_LEN_LO: begin
               len_in  = len_full;
               left_in = len_full;
               if (empty_frame) begin
                  phase_in = lpfd_pkg::PH_CONN_HI;
               end else begin
                  phase_in = lpfd_pkg::PH_PAYLOAD;
               end
            end
            lpfd_pkg::PH_PAYLOAD: begin
               left_in = left_ff - 16'd1;
               if (last_byte) begin
                  phase_in = lpfd_pkg::PH_CONN_HI;
               end
            end
            default: begin
               conn_in  = {byte_data, 8'd0};
               phase_in = lpfd_pkg::PH_CONN_LO;
            end
         endcase
      end
   end

   // Result word.
   always_comb begin
      result.connection_id = conn_ff;
      result.control_field = ctrl_ff;
      if (phase_ff == lpfd_pkg::PH_PAYLOAD) begin
         result.payload_length = len_ff;
         result.payload_byte   = byte_data;
         result.has_data       = 1'b1;
         result.frame_end      = last_byte;
      end else begin
         result.payload_length = len_full;
         result.payload_byte   = 8'd0;
         result.has_data       = 1'b0;
         result.frame_end      = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= lpfd_pkg::PH_CONN_HI;
         conn_ff  <= 16'd0;
         ctrl_ff  <= 16'd0;
         len_ff   <= 16'd0;
         left_ff  <= 16'd0;
      end else begin
         phase_ff <= phase_in;
         conn_ff  <= conn_in;
         ctrl_ff  <= ctrl_in;
         len_ff   <= len_in;
         left_ff  <= left_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/lpfd_out_stage.sv =====
`default_nettype none
module lpfd_out_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  lpfd_pkg::rsp_type result,
   output logic              out_ready,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lpfd_pkg::rsp_type rsp_word
);

   logic              valid_ff;
   logic              valid_in;
   lpfd_pkg::rsp_type word_ff;

   assign out_ready = ~valid_ff | ~rsp_stall;
   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else begin
         valid_in = valid_ff & rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= result;
      end
   end

endmodule
`default_nettype wire

// ===== sv/length_prefixed_frame_deframer.sv =====
// Length-prefixed frame deframer.
// The req channel carries one received byte per word. Frames are a 16-bit
// connection id, a 16-bit control field and a 16-bit payload length, all
// high byte first, followed by that many payload bytes.
// The rsp channel gives one word per payload byte, carrying the byte with the
// frame's header fields; the last payload byte has rsp_frame_end set. A frame
// of zero length gives a single word with rsp_has_data low. Header bytes give
// no word.
// A byte passes through an input register and the parser into the output
// register, so its word is registered twice before it appears on the rsp ports.
// One byte is taken every cycle while the rsp side keeps up.
// When the receiver stalls, the output word holds; one further byte can wait
// in the input register. Header bytes flow on until a payload byte or an
// empty frame's low length byte needs the output register, raising req_stall.
// Synchronous reset empties both registers and returns the parser to the
// start of a frame header.
`default_nettype none
module length_prefixed_frame_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_connection_id,
   output logic [15:0] rsp_control_field,
   output logic [15:0] rsp_payload_length,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_has_data,
   output logic        rsp_frame_end
);

   logic              take;
   logic              emit;
   logic              byte_valid;
   logic [7:0]        byte_data;
   logic              out_ready;
   lpfd_pkg::rsp_type result;
   lpfd_pkg::rsp_type rsp_word;

   lpfd_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .take        (take),
      .byte_valid  (byte_valid),
      .byte_data   (byte_data)
   );

   lpfd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_valid),
      .byte_data  (byte_data),
      .out_ready  (out_ready),
      .take       (take),
      .emit       (emit),
      .result     (result)
   );

   lpfd_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (emit),
      .result    (result),
      .out_ready (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   assign rsp_connection_id  = rsp_word.connection_id;
   assign rsp_control_field  = rsp_word.control_field;
   assign rsp_payload_length = rsp_word.payload_length;
   assign rsp_payload_byte   = rsp_word.payload_byte;
   assign rsp_has_data       = rsp_word.has_data;
   assign rsp_frame_end      = rsp_word.frame_end;

endmodule
`default_nettype wire

// ===== sv/lpfd_checker.sv =====
`default_nettype none
`include "length_prefixed_frame_deframer_defines.svh"
module lpfd_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [15:0] rsp_connection_id,
   input  wire logic [15:0] rsp_control_field,
   input  wire logic [15:0] rsp_payload_length,
   input  wire logic [7:0]  rsp_payload_byte,
   input  wire logic        rsp_has_data,
   input  wire logic        rsp_frame_end
);

   `LPFD_ASSERT_ALWAYS(a_reset_empties, reset |=> !rsp_valid && !req_stall, "reset left a word pending")
   `LPFD_ASSERT(a_stalled_word_holds, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload_byte) && $stable(rsp_connection_id) && $stable(rsp_frame_end), "stalled rsp word changed")
   `LPFD_ASSERT(a_empty_frame_word, rsp_valid && !rsp_has_data |-> rsp_frame_end && rsp_payload_length == 16'd0 && rsp_payload_byte == 8'd0, "malformed empty frame word")
   `LPFD_ASSERT(a_data_needs_length, rsp_valid && rsp_has_data |-> rsp_payload_length != 16'd0, "payload word in a frame of zero length")

endmodule

bind length_prefixed_frame_deframer lpfd_checker u_checker (.*);
`default_nettype wire

// ===== verif/lpfd_frame_checker.sv =====
`default_nettype none
module lpfd_frame_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [15:0] rsp_connection_id,
   input  logic [15:0] rsp_control_field,
   input  logic [15:0] rsp_payload_length,
   input  logic [7:0]  rsp_payload_byte,
   input  logic        rsp_has_data,
   input  logic        rsp_frame_end,
   output int          errors,
   output int          outstanding
);

   lpfd_pkg::phase_type phase;
   logic [15:0]         conn_id;
   logic [15:0]         ctrl_word;
   logic [15:0]         frame_len;
   logic [15:0]         bytes_due;
   lpfd_pkg::rsp_type   expected_words[$];
   lpfd_pkg::rsp_type   got;
   lpfd_pkg::rsp_type   want;

   function automatic bit deframe_byte(input logic [7:0] b,
                                       output lpfd_pkg::rsp_type word);
      bit produced;
      produced = 1'b0;
      word     = '0;
      case (phase)
         lpfd_pkg::PH_CONN_LO: begin
            conn_id = {conn_id[15:8], b};
            phase   = lpfd_pkg::PH_CTRL_HI;
         end
         lpfd_pkg::PH_CTRL_HI: begin
            ctrl_word = {b, 8'h00};
            phase     = lpfd_pkg::PH_CTRL_LO;
         end
         lpfd_pkg::PH_CTRL_LO: begin
            ctrl_word = {ctrl_word[15:8], b};
            phase     = lpfd_pkg::PH_LEN_HI;
         end
         lpfd_pkg::PH_LEN_HI: begin
            frame_len = {b, 8'h00};
            phase     = lpfd_pkg::PH_LEN_LO;
         end
         lpfd_pkg::PH_LEN_LO: begin
            frame_len = {frame_len[15:8], b};
            if (frame_len == 16'h0000) begin
               bytes_due = 16'h0000;
               phase     = lpfd_pkg::PH_CONN_HI;
               word      = {conn_id, ctrl_word, frame_len, 8'h00, 1'b0, 1'b1};
               produced  = 1'b1;
            end else begin
               bytes_due = frame_len;
               phase     = lpfd_pkg::PH_PAYLOAD;
            end
         end
         lpfd_pkg::PH_PAYLOAD: begin
            bytes_due = bytes_due - 16'd1;
            word      = {conn_id, ctrl_word, frame_len, b, 1'b1, bytes_due == 16'h0000};
            produced  = 1'b1;
            if (bytes_due == 16'h0000) begin
               phase = lpfd_pkg::PH_CONN_HI;
            end
         end
         default: begin
            conn_id = {b, 8'h00};
            phase   = lpfd_pkg::PH_CONN_LO;
         end
      endcase
      return produced;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         phase       = lpfd_pkg::PH_CONN_HI;
         conn_id     = 16'h0000;
         ctrl_word   = 16'h0000;
         frame_len   = 16'h0000;
         bytes_due   = 16'h0000;
         errors      = 0;
         outstanding = 0;
         expected_words.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_connection_id, rsp_control_field, rsp_payload_length,
                   rsp_payload_byte, rsp_has_data, rsp_frame_end};
            if (expected_words.size() == 0) begin
               if (errors < 10) begin
                  $display("%0t: unexpected word conn %h ctrl %h len %h byte %h data %b end %b",
                           $time, got.connection_id, got.control_field, got.payload_length,
                           got.payload_byte, got.has_data, got.frame_end);
               end
               errors++;
            end else begin
               want = expected_words.pop_front();
               if (got.connection_id !== want.connection_id ||
                   got.control_field !== want.control_field ||
                   got.payload_length !== want.payload_length ||
                   got.payload_byte !== want.payload_byte ||
                   got.has_data !== want.has_data ||
                   got.frame_end !== want.frame_end) begin
                  if (errors < 10) begin
                     $display("%0t: expected conn %h ctrl %h len %h byte %h data %b end %b",
                              $time, want.connection_id, want.control_field,
                              want.payload_length, want.payload_byte, want.has_data,
                              want.frame_end);
                     $display("%0t: got      conn %h ctrl %h len %h byte %h data %b end %b",
                              $time, got.connection_id, got.control_field,
                              got.payload_length, got.payload_byte, got.has_data,
                              got.frame_end);
                  end
                  errors++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (deframe_byte(req_rx_byte, want)) begin
               expected_words = {expected_words, want};
            end
         end
         outstanding = expected_words.size();
      end
   end

endmodule
`default_nettype wire

// ===== verif/tb_length_prefixed_frame_deframer.sv =====
`default_nettype none
module tb_length_prefixed_frame_deframer;

   localparam int CYCLE_LIMIT    = 200_000;
   localparam int RANDOM_ITEMS   = 1900;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int DRAIN_CYCLES   = 20;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_PERIODIC,
      STALL_HEAVY
   } stall_mode_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_stall   = 1'b0;
   logic        req_stall;
   logic        rsp_valid;
   logic [15:0] rsp_connection_id;
   logic [15:0] rsp_control_field;
   logic [15:0] rsp_payload_length;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_has_data;
   logic        rsp_frame_end;

   int errors;
   int outstanding;
   int cycle_count = 0;
   int burst_left  = 0;
   int bytes_sent  = 0;

   always #5 clock = ~clock;

   length_prefixed_frame_deframer dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_connection_id  (rsp_connection_id),
      .rsp_control_field  (rsp_control_field),
      .rsp_payload_length (rsp_payload_length),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_has_data       (rsp_has_data),
      .rsp_frame_end      (rsp_frame_end)
   );

   lpfd_frame_checker frame_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_connection_id  (rsp_connection_id),
      .rsp_control_field  (rsp_control_field),
      .rsp_payload_length (rsp_payload_length),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_has_data       (rsp_has_data),
      .rsp_frame_end      (rsp_frame_end),
      .errors             (errors),
      .outstanding        (outstanding)
   );

   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
         burst_left = $urandom_range(1, 32);
      end
      burst_left--;
      @(negedge clock);
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   task automatic send_header(input logic [15:0] conn, input logic [15:0] ctrl,
                              input logic [15:0] len);
      send_byte(conn[15:8]);
      send_byte(conn[7:0]);
      send_byte(ctrl[15:8]);
      send_byte(ctrl[7:0]);
      send_byte(len[15:8]);
      send_byte(len[7:0]);
   endtask

   task automatic send_frame(input logic [15:0] conn, input logic [15:0] ctrl,
                             input logic [15:0] len);
      send_header(conn, ctrl, len);
      repeat (len) send_byte(8'($urandom_range(0, 255)));
   endtask

   function automatic logic [15:0] pick_header_word();
      case ($urandom_range(0, 7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [15:0] pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return 16'd0;
      if (r < 70) return 16'($urandom_range(1, 6));
      if (r < 92) return 16'($urandom_range(7, 40));
      return 16'($urandom_range(200, 300));
   endfunction

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin : receiver
      stall_mode_type mode;
      int             span;
      int             segment;
      segment = 0;
      wait (!reset);
      forever begin
         if (segment == 3) begin
            repeat (HOLDOFF_CYCLES) begin
               @(negedge clock);
               rsp_stall <= 1'b1;
            end
         end else begin
            mode = stall_mode_type'($urandom_range(0, 3));
            span = $urandom_range(40, 200);
            repeat (span) begin
               @(negedge clock);
               case (mode)
                  STALL_NONE:     rsp_stall <= 1'b0;
                  STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 9) < 3);
                  STALL_PERIODIC: rsp_stall <= (cycle_count % 3 == 0);
                  default:        rsp_stall <= ($urandom_range(0, 9) < 7);
               endcase
            end
         end
         segment++;
      end
   end

   initial begin : stimulus
      int start;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty frames with all-ones and all-zeros headers, then one- and two-byte frames.
      send_header(16'hFFFF, 16'hFFFF, 16'h0000);
      send_header(16'h0000, 16'h0000, 16'h0000);
      send_header(16'h00FF, 16'hFF00, 16'h0001);
      send_byte(8'hFF);
      send_header(16'h1234, 16'h8001, 16'h0002);
      send_byte(8'h00);
      send_byte(8'h5A);

      start = bytes_sent;
      while (bytes_sent - start < RANDOM_ITEMS) begin
         send_frame(pick_header_word(), pick_header_word(), pick_length());
      end

      @(negedge clock);
      req_valid <= 1'b0;
      wait (outstanding == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && outstanding == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ===== files.f =====
+incdir+sv
sv/lpfd_pkg.sv
sv/lpfd_in_stage.sv
sv/lpfd_parser.sv
sv/lpfd_out_stage.sv
sv/length_prefixed_frame_deframer.sv
sv/lpfd_checker.sv
verif/lpfd_frame_checker.sv
verif/tb_length_prefixed_frame_deframer.sv
